### hw/rtl/hkm_pkg.sv
// ----------------------------------------------------------------------------
// hkm_pkg
// Types, constants and helpers shared by the keyboard report merger files.
// ----------------------------------------------------------------------------
package hkm_pkg;

  localparam int SLOT_COUNT     = 8;
  localparam int FIFO_DEPTH     = 64;
  localparam int KEY_BYTES      = 32;
  localparam int KEYMAP_W       = KEY_BYTES * 8;
  localparam int LATCH_DEPTH    = 224;
  localparam int KEY_FIRST      = 4;
  localparam int KEY_LAST       = 223;
  localparam int MOD_BYTE       = 28;
  localparam int REPORT_W       = 56;
  localparam int SLOT_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_RAM_DEPTH = SLOT_COUNT * KEY_BYTES;
  localparam int SLOT_RAM_AW    = $clog2(SLOT_RAM_DEPTH);
  localparam int KEY_SCAN_N     = (1 << SLOT_W) * KEY_BYTES;
  localparam int SWEEP_N        = (KEY_SCAN_N > LATCH_DEPTH) ? KEY_SCAN_N : LATCH_DEPTH;
  localparam int CNT_W          = $clog2(SWEEP_N);
  localparam int LATCH_AW       = $clog2(LATCH_DEPTH);
  localparam int FIFO_AW        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W          = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_KEYS       = 6;

  localparam logic [15:0] KEY_PAGE = 16'h0007;
  localparam logic [15:0] FN_USAGE = 16'h0003;
  localparam logic [15:0] FN_PAGE0 = 16'h00ff;
  localparam logic [15:0] FN_PAGE1 = 16'hff00;
  localparam logic [15:0] FN_PAGE2 = 16'hff01;

  localparam logic [7:0] KC_ROLLOVER  = 8'h01;
  localparam logic [7:0] ROLLOVER_MSK = 8'h0e;
  localparam logic [7:0] KC_BACKSPACE = 8'h2a;
  localparam logic [7:0] KC_DELETE    = 8'h4c;
  localparam logic [7:0] KC_LEFT      = 8'h50;
  localparam logic [7:0] KC_HOME      = 8'h4a;
  localparam logic [7:0] KC_RIGHT     = 8'h4f;
  localparam logic [7:0] KC_END       = 8'h4d;
  localparam logic [7:0] KC_UP        = 8'h52;
  localparam logic [7:0] KC_PGUP      = 8'h4b;
  localparam logic [7:0] KC_DOWN      = 8'h51;
  localparam logic [7:0] KC_PGDN      = 8'h4e;

  typedef enum logic [2:0] {
    OP_BEGIN   = 3'd0,
    OP_FIELD   = 3'd1,
    OP_END     = 3'd2,
    OP_POP     = 3'd3,
    OP_RESYNC  = 3'd4,
    OP_RELEASE = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_BCLR,
    ST_FRD,
    ST_KEYS,
    ST_LAT,
    ST_SCAN,
    ST_FIN,
    ST_PUSH,
    ST_HRD,
    ST_HLD
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  service;
    logic [15:0] rep_id;
    logic        is_keyboard;
    logic [15:0] usg_page;
    logic [15:0] usage_code;
    logic        field_active;
  } in_item_t;

  typedef struct packed {
    logic       head_valid;
    logic [7:0] head_modifiers;
    logic [7:0] head_key0;
    logic [7:0] head_key1;
    logic [7:0] head_key2;
    logic [7:0] head_key3;
    logic [7:0] head_key4;
    logic [7:0] head_key5;
    logic [6:0] queue_level;
    logic       report_queued;
  } out_item_t;

  function automatic logic [7:0] fn_map(input logic [7:0] key, input logic fn);
    logic [7:0] res;
    res = key;
    if (fn) begin
      unique case (key)
        KC_BACKSPACE: res = KC_DELETE;
        KC_LEFT:      res = KC_HOME;
        KC_RIGHT:     res = KC_END;
        KC_UP:        res = KC_PGUP;
        KC_DOWN:      res = KC_PGDN;
        default:      res = key;
      endcase
    end
    return res;
  endfunction

endpackage

### hw/rtl/hkm_if.sv
// ----------------------------------------------------------------------------
// hkm channel interfaces
// Valid/ready channels for input items, result items and the config write.
// ----------------------------------------------------------------------------
interface hkm_in_if import hkm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hkm_out_if import hkm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hkm_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/hid_keyboard_report_merger.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_merger
// Merges parsed keyboard reports of several slots into 6-key boot reports.
// ----------------------------------------------------------------------------
//  channel | dir | payload                         | transfer
//  in_i    | in  | opcode, slot key, one field     | valid & ready
//  out_o   | out | queue head, level, queued flag  | valid & ready
//  cfg_i   | in  | fn_bridge_enable                | valid & ready
//
//  one item at a time; every item ends with a fifo head read
//  begin: slot bitmap cleared when a slot is taken; field: key bit set in slot ram
//  end: 256 slot ram reads, 220 latch ram read-modify-writes, 220 bitmap scan steps,
//  the ram accesses one at a time through the single read port of each ram
//  reset and release: clearing pass over slot and latch rams
//  a finished result waits in the output register while the next item is taken
module hid_keyboard_report_merger import hkm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hkm_cfg_if.sink    cfg_i,
  hkm_in_if.sink     in_i,
  hkm_out_if.source  out_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic fn_en_q;

  logic              slot_used_q [SLOT_COUNT];
  logic              slot_used_d [SLOT_COUNT];
  logic              slot_fn_q   [SLOT_COUNT];
  logic              slot_fn_d   [SLOT_COUNT];
  logic [7:0]        slot_svc_q  [SLOT_COUNT];
  logic [7:0]        slot_svc_d  [SLOT_COUNT];
  logic [15:0]       slot_rid_q  [SLOT_COUNT];
  logic [15:0]       slot_rid_d  [SLOT_COUNT];
  logic              open_vld_q, open_vld_d;
  logic [SLOT_W-1:0] open_q, open_d;

  logic [REPORT_W-1:0] cur_q, cur_d;
  logic [FIFO_AW-1:0]  head_q, head_d;
  logic [LVL_W-1:0]    level_q, level_d;

  logic [KEYMAP_W-1:0] keys_q, keys_d;
  logic [KEYMAP_W-1:0] mapped_q, mapped_d;
  logic                kacc_vld_q, kacc_vld_d;
  logic [4:0]          kacc_byte_q, kacc_byte_d;
  logic                lat_vld_q, lat_vld_d;
  logic [7:0]          lat_idx_q, lat_idx_d;
  logic [2:0]          n_q, n_d;
  logic [7:0]          outk_q [MAX_KEYS];
  logic [7:0]          outk_d [MAX_KEYS];

  logic [REPORT_W-1:0] push_a_q, push_a_d, push_b_q, push_b_d;
  logic [1:0]          push_cnt_q, push_cnt_d;
  logic                clr_push_q, clr_push_d;
  logic                queued_q, queued_d;
  logic [SLOT_RAM_AW-1:0] faddr_q, faddr_d;
  logic [7:0]          fmask_q, fmask_d;

  out_item_t out_q, out_d;
  logic      out_vld_q, out_vld_d;

  // ram ports
  logic                   s_we, s_re;
  logic [SLOT_RAM_AW-1:0] s_waddr, s_raddr;
  logic [7:0]             s_wdata, s_rdata;
  logic                   l_we, l_re;
  logic [LATCH_AW-1:0]    l_waddr, l_raddr;
  logic [7:0]             l_wdata, l_rdata;
  logic                   f_we, f_re;
  logic [FIFO_AW-1:0]     f_waddr, f_raddr;
  logic [REPORT_W-1:0]    f_wdata, f_rdata;

  hkm_ram #(.Width(8), .Depth(SLOT_RAM_DEPTH)) u_slot_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );
  hkm_ram #(.Width(8), .Depth(LATCH_DEPTH)) u_latch_ram (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .re_i(l_re), .raddr_i(l_raddr), .rdata_o(l_rdata)
  );
  hkm_ram #(.Width(REPORT_W), .Depth(FIFO_DEPTH)) u_fifo_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(f_re), .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // slot lookup for begin
  logic              found_vld, empty_vld, fn_any;
  logic [SLOT_W-1:0] found_idx, empty_idx;
  always_comb begin
    found_vld = 1'b0;
    empty_vld = 1'b0;
    found_idx = '0;
    empty_idx = '0;
    fn_any    = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      fn_any = fn_any | slot_fn_q[i];
      if (!slot_used_q[i]) begin
        empty_vld = 1'b1;
        empty_idx = SLOT_W'(i);
      end else if (slot_svc_q[i] == in_i.data.service &&
                   slot_rid_q[i] == in_i.data.rep_id) begin
        found_vld = 1'b1;
        found_idx = SLOT_W'(i);
      end
    end
  end

  // fifo tail = (head + level) mod depth
  logic [LVL_W:0]     tail_sum;
  logic [FIFO_AW-1:0] tail, head_inc;
  always_comb begin
    tail_sum = {{(LVL_W + 1 - FIFO_AW){1'b0}}, head_q} + {1'b0, level_q};
    if (tail_sum >= (LVL_W + 1)'(FIFO_DEPTH)) begin
      tail_sum = tail_sum - (LVL_W + 1)'(FIFO_DEPTH);
    end
    tail = FIFO_AW'(tail_sum);
    head_inc = (head_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  end

  logic [7:0]          lat_t;
  logic                rollover;
  logic [REPORT_W-1:0] nxt_rep;
  logic                key_hit, fn_hit;
  logic [SLOT_W-1:0]   sel_slot;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    slot_used_d = slot_used_q;
    slot_fn_d   = slot_fn_q;
    slot_svc_d  = slot_svc_q;
    slot_rid_d  = slot_rid_q;
    open_vld_d  = open_vld_q;
    open_d      = open_q;
    cur_d       = cur_q;
    head_d      = head_q;
    level_d     = level_q;
    keys_d      = keys_q;
    mapped_d    = mapped_q;
    kacc_vld_d  = 1'b0;
    kacc_byte_d = kacc_byte_q;
    lat_vld_d   = 1'b0;
    lat_idx_d   = lat_idx_q;
    n_d         = n_q;
    outk_d      = outk_q;
    push_a_d    = push_a_q;
    push_b_d    = push_b_q;
    push_cnt_d  = push_cnt_q;
    clr_push_d  = clr_push_q;
    queued_d    = queued_q;
    faddr_d     = faddr_q;
    fmask_d     = fmask_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q & ~out_o.ready;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_re = 1'b0; l_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
    lat_t    = '0;
    rollover = 1'b0;
    nxt_rep  = '0;
    sel_slot = found_vld ? found_idx : empty_idx;
    key_hit  = in_i.data.usg_page == KEY_PAGE && in_i.data.field_active &&
               in_i.data.usage_code != '0 && in_i.data.usage_code[15:8] == '0;
    fn_hit   = fn_en_q && in_i.data.field_active && in_i.data.usage_code == FN_USAGE &&
               (in_i.data.usg_page == FN_PAGE0 || in_i.data.usg_page == FN_PAGE1 ||
                in_i.data.usg_page == FN_PAGE2);

    // each slot ram read of the key merge is ORed in the cycle after it is issued
    if (kacc_vld_q) begin
      keys_d[{kacc_byte_q, 3'b000} +: 8] = keys_q[{kacc_byte_q, 3'b000} +: 8] | s_rdata;
    end
    // translation latch read-modify-write, one key behind the read
    if (lat_vld_q) begin
      l_we    = 1'b1;
      l_waddr = LATCH_AW'(lat_idx_q);
      if (keys_q[lat_idx_q]) begin
        lat_t = (l_rdata != '0) ? l_rdata : fn_map(lat_idx_q, fn_any & fn_en_q);
        l_wdata = lat_t;
        mapped_d[lat_t] = 1'b1;
      end
    end

    unique case (state_q)
      ST_CLR: begin
        if (int'(cnt_q) < SLOT_RAM_DEPTH) begin
          s_we    = 1'b1;
          s_waddr = SLOT_RAM_AW'(cnt_q);
        end
        if (int'(cnt_q) < LATCH_DEPTH) begin
          l_we    = 1'b1;
          l_waddr = LATCH_AW'(cnt_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SWEEP_N - 1)) begin
          cnt_d = '0;
          if (clr_push_q) begin
            clr_push_d = 1'b0;
            push_a_d   = '0;
            push_cnt_d = 2'd1;
            state_d    = ST_PUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          queued_d = 1'b0;
          state_d  = ST_HRD;
          unique case (in_i.data.opcode)
            OP_BEGIN: begin
              open_vld_d = 1'b0;
              if (in_i.data.is_keyboard) begin
                if (found_vld || empty_vld) begin
                  slot_used_d[sel_slot] = 1'b1;
                  slot_fn_d[sel_slot]   = 1'b0;
                  slot_svc_d[sel_slot]  = in_i.data.service;
                  slot_rid_d[sel_slot]  = in_i.data.rep_id;
                  open_vld_d = 1'b1;
                  open_d     = sel_slot;
                  cnt_d      = '0;
                  state_d    = ST_BCLR;
                end else begin
                  // no free slot: same as release
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                    slot_used_d[i] = 1'b0;
                    slot_fn_d[i]   = 1'b0;
                    slot_svc_d[i]  = '0;
                    slot_rid_d[i]  = '0;
                  end
                  cur_d      = '0;
                  head_d     = '0;
                  level_d    = '0;
                  cnt_d      = '0;
                  clr_push_d = 1'b1;
                  state_d    = ST_CLR;
                end
              end
            end
            OP_FIELD: begin
              if (open_vld_q) begin
                if (fn_hit) begin
                  slot_fn_d[open_q] = 1'b1;
                end
                if (key_hit) begin
                  s_re    = 1'b1;
                  s_raddr = SLOT_RAM_AW'({open_q, in_i.data.usage_code[7:3]});
                  faddr_d = SLOT_RAM_AW'({open_q, in_i.data.usage_code[7:3]});
                  fmask_d = 8'(1) << in_i.data.usage_code[2:0];
                  state_d = ST_FRD;
                end
              end
            end
            OP_END: begin
              if (open_vld_q) begin
                open_vld_d = 1'b0;
                keys_d     = '0;
                mapped_d   = '0;
                n_d        = '0;
                for (int i = 0; i < MAX_KEYS; i++) begin
                  outk_d[i] = '0;
                end
                cnt_d   = '0;
                state_d = ST_KEYS;
              end
            end
            OP_POP: begin
              if (level_q != '0) begin
                head_d  = head_inc;
                level_d = level_q - 1'b1;
              end
            end
            OP_RESYNC: begin
              head_d     = '0;
              level_d    = '0;
              push_a_d   = '0;
              push_b_d   = cur_q;
              push_cnt_d = 2'd2;
              state_d    = ST_PUSH;
            end
            OP_RELEASE: begin
              for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_used_d[i] = 1'b0;
                slot_fn_d[i]   = 1'b0;
                slot_svc_d[i]  = '0;
                slot_rid_d[i]  = '0;
              end
              open_vld_d = 1'b0;
              cur_d      = '0;
              head_d     = '0;
              level_d    = '0;
              cnt_d      = '0;
              clr_push_d = 1'b1;
              state_d    = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_BCLR: begin
        s_we    = 1'b1;
        s_waddr = SLOT_RAM_AW'({open_q, cnt_q[4:0]});
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q[4:0] == 5'(KEY_BYTES - 1)) begin
          cnt_d   = '0;
          state_d = ST_HRD;
        end
      end
      ST_FRD: begin
        s_we    = 1'b1;
        s_waddr = faddr_q;
        s_wdata = s_rdata | fmask_q;
        state_d = ST_HRD;
      end
      ST_KEYS: begin
        // slot index runs fastest, byte index slowest
        if (int'(cnt_q[SLOT_W-1:0]) < SLOT_COUNT) begin
          s_re       = 1'b1;
          s_raddr    = SLOT_RAM_AW'({cnt_q[SLOT_W-1:0], cnt_q[SLOT_W +: 5]});
          kacc_vld_d = 1'b1;
        end
        kacc_byte_d = cnt_q[SLOT_W +: 5];
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(KEY_SCAN_N - 1)) begin
          cnt_d   = CNT_W'(KEY_FIRST);
          state_d = ST_LAT;
        end
      end
      ST_LAT: begin
        l_re      = 1'b1;
        l_raddr   = LATCH_AW'(cnt_q);
        lat_vld_d = 1'b1;
        lat_idx_d = cnt_q[7:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(KEY_LAST)) begin
          cnt_d   = CNT_W'(KEY_FIRST);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (mapped_q[cnt_q[7:0]]) begin
          if (n_q < 3'(MAX_KEYS)) begin
            outk_d[n_q] = cnt_q[7:0];
          end
          if (n_q != 3'd7) begin
            n_d = n_q + 1'b1;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(KEY_LAST)) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        rollover = (n_q > 3'(MAX_KEYS)) || ((keys_q[7:0] & ROLLOVER_MSK) != '0);
        nxt_rep[7:0] = keys_q[MOD_BYTE*8 +: 8];
        for (int i = 0; i < MAX_KEYS; i++) begin
          nxt_rep[8 + 8*i +: 8] = rollover ? KC_ROLLOVER : outk_q[i];
        end
        if (nxt_rep != cur_q) begin
          cur_d      = nxt_rep;
          push_a_d   = nxt_rep;
          push_cnt_d = 2'd1;
          queued_d   = 1'b1;
          state_d    = ST_PUSH;
        end else begin
          state_d = ST_HRD;
        end
      end
      ST_PUSH: begin
        f_we = 1'b1;
        if (level_q == LVL_W'(FIFO_DEPTH)) begin
          // overflow: restart the queue with one released report
          f_waddr = '0;
          f_wdata = '0;
          head_d  = '0;
          level_d = LVL_W'(1);
        end else begin
          f_waddr    = tail;
          f_wdata    = push_a_q;
          level_d    = level_q + 1'b1;
          push_a_d   = push_b_q;
          push_cnt_d = push_cnt_q - 1'b1;
          if (push_cnt_q == 2'd1) begin
            state_d = ST_HRD;
          end
        end
      end
      ST_HRD: begin
        f_re    = (level_q != '0);
        f_raddr = head_q;
        state_d = ST_HLD;
      end
      ST_HLD: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d                = 1'b1;
          out_d.head_valid         = (level_q != '0);
          out_d.head_modifiers     = '0;
          out_d.head_key0          = '0;
          out_d.head_key1          = '0;
          out_d.head_key2          = '0;
          out_d.head_key3          = '0;
          out_d.head_key4          = '0;
          out_d.head_key5          = '0;
          if (level_q != '0) begin
            out_d.head_modifiers = f_rdata[7:0];
            out_d.head_key0      = f_rdata[15:8];
            out_d.head_key1      = f_rdata[23:16];
            out_d.head_key2      = f_rdata[31:24];
            out_d.head_key3      = f_rdata[39:32];
            out_d.head_key4      = f_rdata[47:40];
            out_d.head_key5      = f_rdata[55:48];
          end
          out_d.queue_level   = 7'(level_q);
          out_d.report_queued = queued_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      fn_en_q     <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_used_q[i] <= 1'b0;
        slot_fn_q[i]   <= 1'b0;
        slot_svc_q[i]  <= '0;
        slot_rid_q[i]  <= '0;
      end
      open_vld_q  <= 1'b0;
      open_q      <= '0;
      cur_q       <= '0;
      head_q      <= '0;
      level_q     <= '0;
      kacc_vld_q  <= 1'b0;
      lat_vld_q   <= 1'b0;
      push_cnt_q  <= '0;
      clr_push_q  <= 1'b0;
      queued_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      if (cfg_i.valid) begin
        fn_en_q <= cfg_i.data;
      end
      slot_used_q <= slot_used_d;
      slot_fn_q   <= slot_fn_d;
      slot_svc_q  <= slot_svc_d;
      slot_rid_q  <= slot_rid_d;
      open_vld_q  <= open_vld_d;
      open_q      <= open_d;
      cur_q       <= cur_d;
      head_q      <= head_d;
      level_q     <= level_d;
      kacc_vld_q  <= kacc_vld_d;
      lat_vld_q   <= lat_vld_d;
      push_cnt_q  <= push_cnt_d;
      clr_push_q  <= clr_push_d;
      queued_q    <= queued_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    keys_q      <= keys_d;
    mapped_q    <= mapped_d;
    kacc_byte_q <= kacc_byte_d;
    lat_idx_q   <= lat_idx_d;
    n_q         <= n_d;
    outk_q      <= outk_d;
    push_a_q    <= push_a_d;
    push_b_q    <= push_b_d;
    faddr_q     <= faddr_d;
    fmask_q     <= fmask_d;
    out_q       <= out_d;
  end

endmodule

### hw/rtl/hkm_ram.sv
// ----------------------------------------------------------------------------
// hkm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hkm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hkm_checker.sv
// ----------------------------------------------------------------------------
// hkm_checker
// Port-level checks on the result channel of the report merger.
// ----------------------------------------------------------------------------
module hkm_checker import hkm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // empty queue shows zero modifiers, key0 and key5 in the head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.head_valid |->
      out_data_i.head_modifiers == '0 && out_data_i.head_key0 == '0 &&
      out_data_i.head_key5 == '0)
    else $error("head fields not zero on empty queue");

  a_level_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.head_valid == (out_data_i.queue_level != '0))
    else $error("head_valid disagrees with queue_level");

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> int'(out_data_i.queue_level) <= FIFO_DEPTH)
    else $error("queue_level above depth");

  a_queued_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.report_queued |-> out_data_i.head_valid)
    else $error("queued report but empty queue");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

endmodule

bind hid_keyboard_report_merger hkm_checker u_hkm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
